FILE: src/two_class_priority_thread_scheduler_unit_defines.svh
// Assertion macros used by the scheduler sequencer.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef TWO_CLASS_PRIORITY_THREAD_SCHEDULER_UNIT_DEFINES_SVH
`define TWO_CLASS_PRIORITY_THREAD_SCHEDULER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define TCPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define TCPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TCPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: src/tcps_pkg.sv
// ----------------------------------------------------------------------------
// tcps_pkg
// Types and codes shared by the thread scheduler modules.
// ----------------------------------------------------------------------------
package tcps_pkg;

    // Thread ids and CPU ids are fixed by the field widths.
    localparam int THREAD_W    = 6;
    localparam int CPU_W       = 4;
    localparam int NUM_THREADS = 64;
    localparam int NUM_CPUS    = 16;

    // Command codes on the input beat.
    localparam logic [2:0] CMD_SCHED = 3'd0;
    localparam logic [2:0] CMD_ADD   = 3'd1;
    localparam logic [2:0] CMD_WAKE  = 3'd2;
    localparam logic [2:0] CMD_WAIT  = 3'd3;
    localparam logic [2:0] CMD_REM   = 3'd4;

    // Thread classes.
    localparam logic [1:0] CLS_USER   = 2'd0;
    localparam logic [1:0] CLS_DRIVER = 2'd1;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    typedef enum logic [2:0] {
        OP_SCHED,
        OP_ADD,
        OP_WAKE,
        OP_WAIT,
        OP_REM,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        TS_ABSENT,
        TS_NEW,
        TS_READY,
        TS_WAITING
    } t_tstat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_SCH_CUR,
        S_POP,
        S_POPW,
        S_CHK,
        S_WAKE,
        S_WAIT,
        S_REM
    } t_state;

    typedef struct packed {
        logic [2:0]          command;
        logic [CPU_W-1:0]    cpu_id;
        logic [THREAD_W-1:0] thread_id;
        logic [1:0]          thread_class;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          status;
        logic [THREAD_W-1:0] next_thread;
        logic                first_start;
        logic                context_saved;
        logic                switched;
    } t_out_item;

    // Decoded command as held between front and back.
    typedef struct packed {
        t_op                 op;
        logic [CPU_W-1:0]    cpu;
        logic [THREAD_W-1:0] tid;
        logic [1:0]          cls;
    } t_cmd;

    // Thread table entry.
    typedef struct packed {
        t_tstat     st;
        logic [1:0] cls;
    } t_tent;

    // Control from the sequencer to one ready queue.
    typedef struct packed {
        logic                push;
        logic [THREAD_W-1:0] data;
        logic                pop;
    } t_rq_ctrl;

    // Status from one ready queue.
    typedef struct packed {
        logic empty;
        logic full;
    } t_rq_stat;

endpackage

FILE: src/two_class_priority_thread_scheduler_unit.sv
// ----------------------------------------------------------------------------
// two_class_priority_thread_scheduler_unit
// Strict-priority scheduler with driver and user ready queues.
// ----------------------------------------------------------------------------
// Commands enter a two-beat front queue and are carried out one at a time by
// a sequencer whose speed is set by the registered reads of the thread table
// and of the ready queue memories. After fetch and decode, add and unknown
// codes give their result; wake, wait and remove first read the thread
// table. A schedule reads the running thread's entry and requeues it if
// ready, unless idle keeps running; it then pops the driver or else the
// user queue, reads the popped id's entry and skips stale ids of removed
// threads, or takes the idle thread when both queues are empty. A result
// waits in an output register; the sequencer starts its next command once
// that slot frees. There is no clearing pass after reset.
module two_class_priority_thread_scheduler_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tcps_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tcps_pkg::t_out_item           o_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tcps_pkg::THREAD_W-1:0] i_cfg_data
);

    logic                          cmd_valid;
    tcps_pkg::t_cmd                cmd;
    logic                          cmd_pop;
    tcps_pkg::t_rq_ctrl            drv_ctrl, usr_ctrl;
    tcps_pkg::t_rq_stat            drv_stat, usr_stat;
    logic [tcps_pkg::THREAD_W-1:0] drv_rdata, usr_rdata;
    logic [tcps_pkg::THREAD_W-1:0] r_idle_id;

    // Idle thread register; a write beat is taken in any cycle.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_id <= tcps_pkg::THREAD_W'(1);
        end else if (i_cfg_valid) begin
            r_idle_id <= i_cfg_data;
        end
    end

    tcps_cmd_queue u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    tcps_ready_queue #(.DEPTH(QUEUE_DEPTH)) u_drv_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (drv_ctrl),
        .o_stat  (drv_stat),
        .o_rdata (drv_rdata)
    );

    tcps_ready_queue #(.DEPTH(QUEUE_DEPTH)) u_usr_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (usr_ctrl),
        .o_stat  (usr_stat),
        .o_rdata (usr_rdata)
    );

    tcps_exec u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_idle_id   (r_idle_id),
        .o_drv_ctrl  (drv_ctrl),
        .i_drv_stat  (drv_stat),
        .i_drv_rdata (drv_rdata),
        .o_usr_ctrl  (usr_ctrl),
        .i_usr_stat  (usr_stat),
        .i_usr_rdata (usr_rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

FILE: src/tcps_cmd_queue.sv
// ----------------------------------------------------------------------------
// tcps_cmd_queue
// Front end: accepts command beats, decodes them and holds up to two in a queue.
// ----------------------------------------------------------------------------
module tcps_cmd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tcps_pkg::t_in_item i_in,
    output logic               o_cmd_valid,
    output tcps_pkg::t_cmd     o_cmd,
    input  logic               i_cmd_pop
);

    tcps_pkg::t_cmd r_ent [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    tcps_pkg::t_cmd dec;
    logic           push;

    // Decode the command code; unused codes become a no-op.
    always_comb begin
        dec.cpu = i_in.cpu_id;
        dec.tid = i_in.thread_id;
        dec.cls = i_in.thread_class;
        unique case (i_in.command)
            tcps_pkg::CMD_SCHED: dec.op = tcps_pkg::OP_SCHED;
            tcps_pkg::CMD_ADD:   dec.op = tcps_pkg::OP_ADD;
            tcps_pkg::CMD_WAKE:  dec.op = tcps_pkg::OP_WAKE;
            tcps_pkg::CMD_WAIT:  dec.op = tcps_pkg::OP_WAIT;
            tcps_pkg::CMD_REM:   dec.op = tcps_pkg::OP_REM;
            default:             dec.op = tcps_pkg::OP_NOP;
        endcase
    end

    assign o_in_ready  = (r_count != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_ent[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= dec;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, i_cmd_pop};
        end
    end

endmodule

FILE: src/tcps_ready_queue.sv
// ----------------------------------------------------------------------------
// tcps_ready_queue
// Circular FIFO of ready thread ids with a registered read port.
// ----------------------------------------------------------------------------
module tcps_ready_queue #(
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tcps_pkg::t_rq_ctrl               i_ctrl,
    output tcps_pkg::t_rq_stat               o_stat,
    output logic [tcps_pkg::THREAD_W-1:0]    o_rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [tcps_pkg::THREAD_W-1:0] r_mem [DEPTH];
    logic [tcps_pkg::THREAD_W-1:0] r_rdata;
    logic [AW-1:0]                 r_head;
    logic [AW-1:0]                 r_tail;
    logic [CW-1:0]                 r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_stat.empty = (r_count == CW'(0));
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push      = i_ctrl.push && !o_stat.full;
    assign do_pop       = i_ctrl.pop && !o_stat.empty;
    assign o_rdata      = r_rdata;

    // Storage: write at the tail, registered read at the head.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_ctrl.data;
        end
        if (do_pop) begin
            r_rdata <= r_mem[r_head];
        end
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_tail <= (r_tail == AW'(DEPTH - 1)) ? '0 : r_tail + AW'(1);
            end
            if (do_pop) begin
                r_head <= (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

endmodule

FILE: src/tcps_exec.sv
// ----------------------------------------------------------------------------
// tcps_exec
// Back end: sequencer that carries out one command against the thread
// table, the per-CPU running table and the two ready queues.
// ----------------------------------------------------------------------------
`include "two_class_priority_thread_scheduler_unit_defines.svh"

module tcps_exec (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  tcps_pkg::t_cmd                i_cmd,
    output logic                          o_cmd_pop,
    input  logic [tcps_pkg::THREAD_W-1:0] i_idle_id,
    output tcps_pkg::t_rq_ctrl            o_drv_ctrl,
    input  tcps_pkg::t_rq_stat            i_drv_stat,
    input  logic [tcps_pkg::THREAD_W-1:0] i_drv_rdata,
    output tcps_pkg::t_rq_ctrl            o_usr_ctrl,
    input  tcps_pkg::t_rq_stat            i_usr_stat,
    input  logic [tcps_pkg::THREAD_W-1:0] i_usr_rdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tcps_pkg::t_out_item           o_out
);

    localparam int TW = tcps_pkg::THREAD_W;

    tcps_pkg::t_state    r_state, n_state;
    tcps_pkg::t_cmd      r_cmd, n_cmd;
    logic [TW-1:0]       r_pick, n_pick;
    logic                r_from_q, n_from_q;
    logic                r_qsel, n_qsel;
    logic [1:0]          r_st, n_st;
    logic                r_saved, n_saved;
    logic                r_out_valid, n_out_valid;
    tcps_pkg::t_out_item r_out, n_out;

    // Thread table with valid bits, and the per-CPU running table.
    tcps_pkg::t_tent      r_tmem [tcps_pkg::NUM_THREADS];
    logic [tcps_pkg::NUM_THREADS-1:0] r_tvalid;
    tcps_pkg::t_tent      r_trd;
    logic                 r_trd_vld;
    logic [TW-1:0]        r_running [tcps_pkg::NUM_CPUS];

    logic [TW-1:0]        t_ra;
    logic                 t_we;
    logic [TW-1:0]        t_wa;
    tcps_pkg::t_tent      t_wd;
    logic                 run_we;
    logic [TW-1:0]        cur;
    tcps_pkg::t_tstat     rd_st;
    logic                 rd_known;
    logic [TW-1:0]        qdata;

    assign cur      = r_running[r_cmd.cpu];
    assign rd_st    = r_trd_vld ? r_trd.st : tcps_pkg::TS_ABSENT;
    assign rd_known = (rd_st != tcps_pkg::TS_ABSENT);
    assign qdata    = r_qsel ? i_usr_rdata : i_drv_rdata;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sequencer: next state, table accesses, queue control and result.
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pick      = r_pick;
        n_from_q    = r_from_q;
        n_qsel      = r_qsel;
        n_st        = r_st;
        n_saved     = r_saved;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd_pop   = 1'b0;
        t_ra        = '0;
        t_we        = 1'b0;
        t_wa        = r_cmd.tid;
        t_wd        = '{st: tcps_pkg::TS_NEW, cls: r_cmd.cls};
        run_we      = 1'b0;
        o_drv_ctrl  = '0;
        o_usr_ctrl  = '0;

        unique case (r_state)
            tcps_pkg::S_IDLE: begin
                if (i_cmd_valid && (!r_out_valid || i_out_ready)) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_st      = tcps_pkg::ST_OK;
                    n_saved   = 1'b0;
                    n_state   = tcps_pkg::S_DEC;
                end
            end
            tcps_pkg::S_DEC: begin
                n_out   = '0;
                n_state = tcps_pkg::S_IDLE;
                unique case (r_cmd.op)
                    tcps_pkg::OP_SCHED: begin
                        t_ra    = cur;
                        n_state = tcps_pkg::S_SCH_CUR;
                    end
                    tcps_pkg::OP_ADD: begin
                        t_we = 1'b1;
                        if (r_cmd.cls == tcps_pkg::CLS_USER) begin
                            o_usr_ctrl = '{push: 1'b1, data: r_cmd.tid, pop: 1'b0};
                            n_out.status = i_usr_stat.full ? tcps_pkg::ST_FULL
                                                           : tcps_pkg::ST_OK;
                        end else if (r_cmd.cls == tcps_pkg::CLS_DRIVER) begin
                            o_drv_ctrl = '{push: 1'b1, data: r_cmd.tid, pop: 1'b0};
                            n_out.status = i_drv_stat.full ? tcps_pkg::ST_FULL
                                                           : tcps_pkg::ST_OK;
                        end
                        n_out_valid = 1'b1;
                    end
                    tcps_pkg::OP_WAKE: begin
                        t_ra    = r_cmd.tid;
                        n_state = tcps_pkg::S_WAKE;
                    end
                    tcps_pkg::OP_WAIT: begin
                        t_ra    = cur;
                        n_state = tcps_pkg::S_WAIT;
                    end
                    tcps_pkg::OP_REM: begin
                        t_ra    = r_cmd.tid;
                        n_state = tcps_pkg::S_REM;
                    end
                    default: begin
                        n_out_valid = 1'b1;
                    end
                endcase
            end
            tcps_pkg::S_SCH_CUR: begin
                if (cur == i_idle_id && i_drv_stat.empty && i_usr_stat.empty &&
                    rd_st == tcps_pkg::TS_READY) begin
                    // Idle keeps running with nothing else ready.
                    n_out.next_thread = cur;
                    n_out_valid       = 1'b1;
                    n_state           = tcps_pkg::S_IDLE;
                end else begin
                    if (rd_st == tcps_pkg::TS_READY) begin
                        n_saved = 1'b1;
                        if (r_trd.cls == tcps_pkg::CLS_USER) begin
                            o_usr_ctrl = '{push: 1'b1, data: cur, pop: 1'b0};
                            n_st = i_usr_stat.full ? tcps_pkg::ST_FULL : tcps_pkg::ST_OK;
                        end else if (r_trd.cls == tcps_pkg::CLS_DRIVER) begin
                            o_drv_ctrl = '{push: 1'b1, data: cur, pop: 1'b0};
                            n_st = i_drv_stat.full ? tcps_pkg::ST_FULL : tcps_pkg::ST_OK;
                        end
                    end else if (rd_st == tcps_pkg::TS_WAITING) begin
                        n_saved = 1'b1;
                    end
                    n_state = tcps_pkg::S_POP;
                end
            end
            tcps_pkg::S_POP: begin
                // Driver queue first, then user queue, then the idle thread.
                if (!i_drv_stat.empty) begin
                    o_drv_ctrl.pop = 1'b1;
                    n_qsel         = 1'b0;
                    n_state        = tcps_pkg::S_POPW;
                end else if (!i_usr_stat.empty) begin
                    o_usr_ctrl.pop = 1'b1;
                    n_qsel         = 1'b1;
                    n_state        = tcps_pkg::S_POPW;
                end else begin
                    n_pick   = i_idle_id;
                    n_from_q = 1'b0;
                    t_ra     = i_idle_id;
                    n_state  = tcps_pkg::S_CHK;
                end
            end
            tcps_pkg::S_POPW: begin
                n_pick   = qdata;
                n_from_q = 1'b1;
                t_ra     = qdata;
                n_state  = tcps_pkg::S_CHK;
            end
            tcps_pkg::S_CHK: begin
                if (r_from_q && !rd_known) begin
                    // Stale entry of a removed thread: skip it.
                    n_state = tcps_pkg::S_POP;
                end else begin
                    run_we              = 1'b1;
                    n_out.next_thread   = r_pick;
                    n_out.context_saved = r_saved;
                    n_out.switched      = 1'b1;
                    n_out.status        = rd_known ? r_st : tcps_pkg::ST_UNKNOWN;
                    if (rd_st == tcps_pkg::TS_NEW) begin
                        t_we              = 1'b1;
                        t_wa              = r_pick;
                        t_wd              = '{st: tcps_pkg::TS_READY, cls: r_trd.cls};
                        n_out.first_start = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_state     = tcps_pkg::S_IDLE;
                end
            end
            tcps_pkg::S_WAKE: begin
                if (!rd_known) begin
                    n_out.status = tcps_pkg::ST_UNKNOWN;
                end else if (rd_st == tcps_pkg::TS_WAITING) begin
                    t_we = 1'b1;
                    t_wd = '{st: tcps_pkg::TS_READY, cls: r_trd.cls};
                    if (r_trd.cls == tcps_pkg::CLS_DRIVER) begin
                        o_drv_ctrl = '{push: 1'b1, data: r_cmd.tid, pop: 1'b0};
                        n_out.status = i_drv_stat.full ? tcps_pkg::ST_FULL
                                                       : tcps_pkg::ST_OK;
                    end else begin
                        o_usr_ctrl = '{push: 1'b1, data: r_cmd.tid, pop: 1'b0};
                        n_out.status = i_usr_stat.full ? tcps_pkg::ST_FULL
                                                       : tcps_pkg::ST_OK;
                    end
                end
                n_out_valid = 1'b1;
                n_state     = tcps_pkg::S_IDLE;
            end
            tcps_pkg::S_WAIT: begin
                if (!rd_known) begin
                    n_out.status = tcps_pkg::ST_UNKNOWN;
                end else begin
                    t_we = 1'b1;
                    t_wa = cur;
                    t_wd = '{st: tcps_pkg::TS_WAITING, cls: r_trd.cls};
                end
                n_out_valid = 1'b1;
                n_state     = tcps_pkg::S_IDLE;
            end
            tcps_pkg::S_REM: begin
                if (!rd_known) begin
                    n_out.status = tcps_pkg::ST_UNKNOWN;
                end else begin
                    t_we = 1'b1;
                    t_wd = '{st: tcps_pkg::TS_ABSENT, cls: r_trd.cls};
                end
                n_out_valid = 1'b1;
                n_state     = tcps_pkg::S_IDLE;
            end
            default: begin
                n_state = tcps_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer state and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcps_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers of the command in flight and of the result.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_pick   <= n_pick;
        r_from_q <= n_from_q;
        r_qsel   <= n_qsel;
        r_st     <= n_st;
        r_saved  <= n_saved;
        r_out    <= n_out;
    end

    // Thread table storage with registered read.
    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_tmem[t_wa] <= t_wd;
        end
        r_trd <= r_tmem[t_ra];
    end

    // Entry valid bits: an entry never written reads as absent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid  <= '0;
            r_trd_vld <= 1'b0;
        end else begin
            if (t_we) begin
                r_tvalid[t_wa] <= 1'b1;
            end
            r_trd_vld <= r_tvalid[t_ra];
        end
    end

    // Running thread of each CPU.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tcps_pkg::NUM_CPUS; i++) begin
                r_running[i] <= '0;
            end
        end else if (run_we) begin
            r_running[r_cmd.cpu] <= r_pick;
        end
    end

    `TCPS_ASSERT_IMP(a_fetch_slot_free, i_clk, i_rst_n, o_cmd_pop,
        !r_out_valid || i_out_ready, "command fetched while result slot busy")
    `TCPS_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n,
        (o_drv_ctrl.pop && i_drv_stat.empty) || (o_usr_ctrl.pop && i_usr_stat.empty),
        1'b0, "ready queue popped while empty")
    `TCPS_ASSERT_IMP(a_busy_no_result, i_clk, i_rst_n,
        r_state == tcps_pkg::S_SCH_CUR || r_state == tcps_pkg::S_POP,
        !r_out_valid, "result pending while a schedule is in progress")

endmodule

FILE: verif/tcps_checker.sv
// ----------------------------------------------------------------------------
// tcps_checker
// Watches the command, result and register channels of the scheduler, keeps
// its own copy of the thread table, the running table and both ready queues,
// and compares every result beat with the predicted one in order.
// ----------------------------------------------------------------------------
module tcps_checker #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  tcps_pkg::t_in_item            i_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  tcps_pkg::t_out_item           i_out,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [tcps_pkg::THREAD_W-1:0] i_cfg_data,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_results
);
    import tcps_pkg::*;

    localparam int Q_DRV = 0;
    localparam int Q_USR = 1;

    // Shadow scheduler state.
    t_tstat              thr_stat [NUM_THREADS];
    logic [1:0]          thr_cls  [NUM_THREADS];
    logic [THREAD_W-1:0] run_tid  [NUM_CPUS];
    logic [THREAD_W-1:0] rq_mem   [2][QUEUE_DEPTH];
    int                  rq_head  [2];
    int                  rq_cnt   [2];
    logic [THREAD_W-1:0] idle_tid;

    // Results still owed by the block, oldest first.
    t_out_item           owed_results [$];

    function automatic bit is_known(logic [THREAD_W-1:0] id);
        return thr_stat[id] != TS_ABSENT;
    endfunction

    function automatic logic [1:0] rq_push(int q, logic [THREAD_W-1:0] id);
        if (rq_cnt[q] >= QUEUE_DEPTH)
            return ST_FULL;
        rq_mem[q][(rq_head[q] + rq_cnt[q]) % QUEUE_DEPTH] = id;
        rq_cnt[q]++;
        return ST_OK;
    endfunction

    function automatic logic [THREAD_W-1:0] rq_pop(int q);
        logic [THREAD_W-1:0] id;
        id = rq_mem[q][rq_head[q]];
        rq_head[q] = (rq_head[q] + 1) % QUEUE_DEPTH;
        rq_cnt[q]--;
        return id;
    endfunction

    // Apply one command to the shadow state and return the result it causes.
    function automatic t_out_item run_command(t_in_item it);
        t_out_item           res;
        logic [THREAD_W-1:0] cur;
        logic [THREAD_W-1:0] pick;
        bit                  done;
        res = '0;
        case (it.command)
            CMD_SCHED: begin
                cur = run_tid[it.cpu_id];
                if (cur == idle_tid && rq_cnt[Q_DRV] == 0 && rq_cnt[Q_USR] == 0 &&
                    is_known(cur) && thr_stat[cur] == TS_READY) begin
                    res.next_thread = cur;
                end else begin
                    res.switched = 1'b1;
                    if (is_known(cur)) begin
                        if (thr_stat[cur] == TS_READY) begin
                            res.context_saved = 1'b1;
                            if (thr_cls[cur] == CLS_USER)
                                res.status = rq_push(Q_USR, cur);
                            else if (thr_cls[cur] == CLS_DRIVER)
                                res.status = rq_push(Q_DRV, cur);
                        end else if (thr_stat[cur] == TS_WAITING) begin
                            res.context_saved = 1'b1;
                        end
                    end
                    // Drivers first, then users; stale ids are skipped.
                    done = 0;
                    pick = idle_tid;
                    while (!done) begin
                        if (rq_cnt[Q_DRV] > 0) begin
                            pick = rq_pop(Q_DRV);
                        end else if (rq_cnt[Q_USR] > 0) begin
                            pick = rq_pop(Q_USR);
                        end else begin
                            pick = idle_tid;
                            done = 1;
                        end
                        if (is_known(pick))
                            done = 1;
                    end
                    run_tid[it.cpu_id] = pick;
                    res.next_thread = pick;
                    if (!is_known(pick)) begin
                        res.status = ST_UNKNOWN;
                    end else if (thr_stat[pick] == TS_NEW) begin
                        thr_stat[pick] = TS_READY;
                        res.first_start = 1'b1;
                    end
                end
            end
            CMD_ADD: begin
                thr_stat[it.thread_id] = TS_NEW;
                thr_cls[it.thread_id] = it.thread_class;
                if (it.thread_class == CLS_USER)
                    res.status = rq_push(Q_USR, it.thread_id);
                else if (it.thread_class == CLS_DRIVER)
                    res.status = rq_push(Q_DRV, it.thread_id);
            end
            CMD_WAKE: begin
                if (!is_known(it.thread_id)) begin
                    res.status = ST_UNKNOWN;
                end else if (thr_stat[it.thread_id] == TS_WAITING) begin
                    thr_stat[it.thread_id] = TS_READY;
                    res.status = rq_push(thr_cls[it.thread_id] == CLS_DRIVER ? Q_DRV : Q_USR,
                                         it.thread_id);
                end
            end
            CMD_WAIT: begin
                cur = run_tid[it.cpu_id];
                if (!is_known(cur))
                    res.status = ST_UNKNOWN;
                else
                    thr_stat[cur] = TS_WAITING;
            end
            CMD_REM: begin
                if (!is_known(it.thread_id))
                    res.status = ST_UNKNOWN;
                else
                    thr_stat[it.thread_id] = TS_ABSENT;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Track beats on all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_THREADS; t++) begin
                thr_stat[t] = TS_ABSENT;
                thr_cls[t] = '0;
            end
            for (int c = 0; c < NUM_CPUS; c++)
                run_tid[c] = '0;
            rq_head = '{0, 0};
            rq_cnt = '{0, 0};
            idle_tid = 6'd1;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                idle_tid = i_cfg_data;
            if (i_in_valid && i_in_ready)
                owed_results.push_back(run_command(i_in));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (owed_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("checker: result beat %h with nothing outstanding", i_out);
                end else begin
                    want = owed_results.pop_front();
                    if (want.status !== i_out.status ||
                        want.next_thread !== i_out.next_thread ||
                        want.first_start !== i_out.first_start ||
                        want.context_saved !== i_out.context_saved ||
                        want.switched !== i_out.switched) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("checker: mismatch expected st=%0d nxt=%0d fs=%0d cs=%0d sw=%0d, got st=%0d nxt=%0d fs=%0d cs=%0d sw=%0d",
                                     want.status, want.next_thread, want.first_start,
                                     want.context_saved, want.switched, i_out.status,
                                     i_out.next_thread, i_out.first_start,
                                     i_out.context_saved, i_out.switched);
                    end
                end
            end
        end
        o_pending = owed_results.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
    end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random scheduler commands through the block with random
// gaps and stalls on both sides, rewrites the idle thread between phases and
// reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module testbench;
    import tcps_pkg::*;

    localparam int HALF_HI    = 6;
    localparam int HALF_LO    = 6;
    localparam int QUIET_MAX  = 5000;
    localparam int DRAIN_WAIT = 40;
    localparam int PHASE_LEN  = 670;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    t_in_item            in_beat;
    logic                out_valid;
    logic                out_ready;
    t_out_item           out_beat;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [THREAD_W-1:0] cfg_data;

    int                  errors;
    int                  pending;
    int                  results;
    int                  snd_idle_pct;
    int                  rcv_idle_pct;
    int                  stall_left;
    bit                  stall_req;
    bit                  stall_seen;
    int                  quiet_cycles;
    int                  sent;

    two_class_priority_thread_scheduler_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    tcps_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_beat),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #HALF_LO i_clk = 1'b1;
        #HALF_HI i_clk = 1'b0;
    end

    // Result side: random stalls, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (stall_req != stall_seen) begin
                stall_seen = stall_req;
                stall_left = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any beat.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Offer one command beat and hold it until it is taken.
    task automatic send_cmd(t_in_item it);
        bit taken;
        if ($urandom_range(99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat <= it;
        do begin
            @(negedge i_clk);
            taken = in_ready;
            @(posedge i_clk);
        end while (!taken);
        sent++;
    endtask

    function automatic t_in_item mk_cmd(logic [2:0] c, int cpu, int tid, int cls);
        t_in_item it;
        it.command = c;
        it.cpu_id = CPU_W'(cpu);
        it.thread_id = THREAD_W'(tid);
        it.thread_class = 2'(cls);
        return it;
    endfunction

    // Mostly commands on a small pool of threads so that the queues and the
    // thread states interact; add_pct shifts the mix toward filling the queues.
    function automatic t_in_item rand_cmd(int add_pct);
        t_in_item it;
        int       r;
        r = $urandom_range(99);
        it.cpu_id = CPU_W'(($urandom_range(3) == 0) ? $urandom_range(15)
                                                    : $urandom_range(3));
        it.thread_id = THREAD_W'(($urandom_range(4) == 0) ? $urandom_range(63)
                                                          : $urandom_range(11));
        it.thread_class = 2'(($urandom_range(9) == 0) ? $urandom_range(2, 3)
                                                      : $urandom_range(1));
        if (r < 3)
            it.command = 3'($urandom_range(5, 7));
        else if (r < 3 + add_pct)
            it.command = CMD_ADD;
        else if (r < 40 + add_pct)
            it.command = CMD_SCHED;
        else if (r < 55 + add_pct)
            it.command = CMD_WAKE;
        else if (r < 70 + add_pct)
            it.command = CMD_WAIT;
        else
            it.command = CMD_REM;
        return it;
    endfunction

    // Wait until the block has returned everything, then let it settle.
    task automatic drain;
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_idle(logic [THREAD_W-1:0] v);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do begin
            @(negedge i_clk);
            taken = cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [THREAD_W-1:0] idle_vals [3];
        int                  add_pcts [3];
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_beat = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        out_ready = 1'b0;
        stall_req = 0;
        stall_seen = 0;
        quiet_cycles = 0;
        sent = 0;
        snd_idle_pct = 31;
        rcv_idle_pct = 52;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle fallback unknown, first start of idle, idle staying,
        // class priority, requeue, wait and wake, bad codes.
        send_cmd(mk_cmd(CMD_SCHED, 0, 0, 0));
        send_cmd(mk_cmd(CMD_ADD, 0, 1, 2));
        send_cmd(mk_cmd(CMD_SCHED, 0, 0, 0));
        send_cmd(mk_cmd(CMD_SCHED, 0, 0, 0));
        send_cmd(mk_cmd(CMD_ADD, 0, 5, CLS_USER));
        send_cmd(mk_cmd(CMD_ADD, 0, 6, CLS_DRIVER));
        send_cmd(mk_cmd(CMD_ADD, 0, 63, 3));
        send_cmd(mk_cmd(CMD_SCHED, 15, 0, 0));
        send_cmd(mk_cmd(CMD_SCHED, 15, 0, 0));
        send_cmd(mk_cmd(CMD_WAIT, 15, 0, 0));
        send_cmd(mk_cmd(CMD_SCHED, 15, 0, 0));
        send_cmd(mk_cmd(CMD_WAKE, 0, 6, 0));
        send_cmd(mk_cmd(CMD_WAKE, 0, 5, 0));
        send_cmd(mk_cmd(CMD_WAKE, 0, 40, 0));
        send_cmd(mk_cmd(CMD_REM, 0, 5, 0));
        send_cmd(mk_cmd(CMD_SCHED, 1, 0, 0));
        send_cmd(mk_cmd(CMD_REM, 0, 40, 0));
        send_cmd(mk_cmd(3'd5, 0, 0, 0));
        send_cmd(mk_cmd(3'd6, 15, 63, 3));
        send_cmd(mk_cmd(3'd7, 7, 21, 1));
        send_cmd(mk_cmd(CMD_WAIT, 4, 0, 0));
        send_cmd(mk_cmd(CMD_ADD, 0, 0, CLS_USER));
        send_cmd(mk_cmd(CMD_WAIT, 4, 0, 0));
        send_cmd(mk_cmd(CMD_SCHED, 15, 63, 3));
        drain();

        // Random phases, each with its own idle thread and traffic shape.
        idle_vals = '{6'd63, 6'd0, 6'($urandom_range(63))};
        add_pcts = '{20, 45, 15};
        for (int p = 0; p < 3; p++) begin
            write_idle(idle_vals[p]);
            if (p == 1) begin
                snd_idle_pct = 52;
                rcv_idle_pct = 31;
            end else if (p == 2) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
                stall_req = !stall_req;
            end
            for (int n = 0; n < PHASE_LEN; n++)
                send_cmd(rand_cmd(add_pcts[p]));
            drain();
        end

        $display("testbench: %0d commands sent, %0d results checked over three idle-thread",
                 sent, results);
        $display("testbench: settings with sender and receiver stalls and one long hold-off");
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/tcps_pkg.sv
src/tcps_cmd_queue.sv
src/tcps_ready_queue.sv
src/tcps_exec.sv
src/two_class_priority_thread_scheduler_unit.sv
verif/tcps_checker.sv
verif/testbench.sv
